[src/cau_pkg.sv]
// Shared types, widths and helpers for the complex arithmetic unit.
// Depends on nothing; imported by complex_arithmetic_unit_core.
package cau_pkg;

	localparam int DW  = 16;          // operand and result width
	localparam int FB  = 8;           // fraction bits
	localparam int SW  = DW + 1;      // add/sub sum width
	localparam int PW  = 2 * DW;      // product width
	localparam int XW  = PW + 2;      // combined product sum width
	localparam int MW  = PW;          // divide numerator magnitude width
	localparam int NW  = MW + FB;     // scaled numerator width
	localparam int QW  = DW + 1;      // quotient bits kept
	localparam int DNW = PW;          // denominator width
	localparam int CW  = DNW + QW + FB; // divider compare width
	localparam int NS  = QW + 4;      // pipeline stages, input to output

	localparam logic [XW-1:0] LIM  = XW'(1) << (DW - 1);
	localparam logic [XW-1:0] HALF = (XW'(1) << FB) >> 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		op_t                   opcode;
		logic signed [DW-1:0]  a_real;
		logic signed [DW-1:0]  a_imag;
		logic signed [DW-1:0]  b_real;
		logic signed [DW-1:0]  b_imag;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0]  res_real;
		logic signed [DW-1:0]  res_imag;
		status_t               status;
	} rsp_t;

	// stage 1: raw products and add/sub sums
	typedef struct packed {
		op_t                   op;
		logic signed [PW-1:0]  ac;
		logic signed [PW-1:0]  bd;
		logic signed [PW-1:0]  ad;
		logic signed [PW-1:0]  bc;
		logic [PW-1:0]         cc;
		logic [PW-1:0]         dd;
		logic signed [SW-1:0]  sre;
		logic signed [SW-1:0]  sim;
		logic                  dz;
	} prd_t;

	// stage 2: combined real/imag terms and denominator
	typedef struct packed {
		op_t                   op;
		logic signed [XW-1:0]  xre;
		logic signed [XW-1:0]  xim;
		logic [DNW-1:0]        den;
		logic                  dz;
	} cmb_t;

	// divider stages; fin holds the finished word for non-divide ops
	typedef struct packed {
		op_t                   op;
		logic                  dz;
		logic                  neg_re;
		logic                  neg_im;
		logic                  ovf_re;
		logic                  ovf_im;
		logic [NW-1:0]         rem_re;
		logic [NW-1:0]         rem_im;
		logic [QW-1:0]         q_re;
		logic [QW-1:0]         q_im;
		logic [DNW-1:0]        den;
		rsp_t                  fin;
	} dv_t;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          sat;
	} sv_t;

	// clamp a sign/magnitude value to the signed DW range
	function automatic sv_t sat_fn(input logic neg, input logic [XW-1:0] mag);
		sv_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (mag > LIM) begin
				r.val = DW'(LIM);
				r.sat = 1'b1;
			end else begin
				r.val = DW'(XW'(0) - mag);
			end
		end else begin
			if (mag > LIM - XW'(1)) begin
				r.val = DW'(LIM - XW'(1));
				r.sat = 1'b1;
			end else begin
				r.val = DW'(mag);
			end
		end
		return r;
	endfunction

endpackage

[src/complex_arithmetic_unit_core.sv]
// Complex ALU: add, subtract, multiply, divide on signed Q8.8 operand pairs.
// Depends on cau_pkg (types, widths, saturation helper).
//
// Takes one word per cycle while req_stall is low and returns one result
// word per input, in order. The divider resolves one of its 17 quotient bits
// per pipeline stage; products sit in stage 1, their sums in stage 2, and
// scaling, rounding and saturation in stage 3 and the last stage. Empty stages
// close up under output stall, so input is taken while any stage is free.
module complex_arithmetic_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cau_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cau_pkg::rsp_t rsp
);
	import cau_pkg::*;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] ld;

	prd_t prd_s1, prd_d;
	cmb_t cmb_s2, cmb_d;
	dv_t  dv_s3 [0:QW];
	dv_t  dv_d;
	rsp_t res_sl, res_d;

	// a stage loads when empty or when its word moves on
	always_comb begin
		ld[NS-1] = !vld_s[NS-1] || !rsp_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	assign req_stall = !ld[0];
	assign rsp_valid = vld_s[NS-1];
	assign rsp       = res_sl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0]) begin
				vld_s[0] <= req_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: products
	always_comb begin
		prd_d.op = req.opcode;
		prd_d.ac = PW'(req.a_real) * PW'(req.b_real);
		prd_d.bd = PW'(req.a_imag) * PW'(req.b_imag);
		prd_d.ad = PW'(req.a_real) * PW'(req.b_imag);
		prd_d.bc = PW'(req.a_imag) * PW'(req.b_real);
		prd_d.cc = $unsigned(PW'(req.b_real) * PW'(req.b_real));
		prd_d.dd = $unsigned(PW'(req.b_imag) * PW'(req.b_imag));
		if (req.opcode == OP_SUB) begin
			prd_d.sre = SW'(req.a_real) - SW'(req.b_real);
			prd_d.sim = SW'(req.a_imag) - SW'(req.b_imag);
		end else begin
			prd_d.sre = SW'(req.a_real) + SW'(req.b_real);
			prd_d.sim = SW'(req.a_imag) + SW'(req.b_imag);
		end
		prd_d.dz = (req.b_real == '0) && (req.b_imag == '0);
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			prd_s1 <= prd_d;
		end
	end

	// stage 2: combine terms
	always_comb begin
		cmb_d.op  = prd_s1.op;
		cmb_d.dz  = prd_s1.dz;
		cmb_d.den = DNW'(prd_s1.cc + prd_s1.dd);
		case (prd_s1.op)
			OP_MUL: begin
				cmb_d.xre = XW'(prd_s1.ac) - XW'(prd_s1.bd);
				cmb_d.xim = XW'(prd_s1.ad) + XW'(prd_s1.bc);
			end
			OP_DIV: begin
				cmb_d.xre = XW'(prd_s1.ac) + XW'(prd_s1.bd);
				cmb_d.xim = XW'(prd_s1.bc) - XW'(prd_s1.ad);
			end
			default: begin
				cmb_d.xre = XW'(prd_s1.sre);
				cmb_d.xim = XW'(prd_s1.sim);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			cmb_s2 <= cmb_d;
		end
	end

	// stage 3: magnitudes, rounding for multiply, saturation, divider setup
	logic [XW-1:0] mag_re, mag_im, rnd_re, rnd_im;
	sv_t           sat_re, sat_im;

	always_comb begin
		mag_re = cmb_s2.xre[XW-1] ? $unsigned(-cmb_s2.xre) : $unsigned(cmb_s2.xre);
		mag_im = cmb_s2.xim[XW-1] ? $unsigned(-cmb_s2.xim) : $unsigned(cmb_s2.xim);
		if (cmb_s2.op == OP_MUL) begin
			rnd_re = (mag_re + HALF) >> FB;
			rnd_im = (mag_im + HALF) >> FB;
		end else begin
			rnd_re = mag_re;
			rnd_im = mag_im;
		end
		sat_re = sat_fn(cmb_s2.xre[XW-1], rnd_re);
		sat_im = sat_fn(cmb_s2.xim[XW-1], rnd_im);

		dv_d.op     = cmb_s2.op;
		dv_d.dz     = cmb_s2.dz;
		dv_d.neg_re = cmb_s2.xre[XW-1];
		dv_d.neg_im = cmb_s2.xim[XW-1];
		dv_d.rem_re = NW'(mag_re[MW-1:0]) << FB;
		dv_d.rem_im = NW'(mag_im[MW-1:0]) << FB;
		dv_d.ovf_re = CW'(dv_d.rem_re) >= (CW'(cmb_s2.den) << QW);
		dv_d.ovf_im = CW'(dv_d.rem_im) >= (CW'(cmb_s2.den) << QW);
		dv_d.q_re   = '0;
		dv_d.q_im   = '0;
		dv_d.den    = cmb_s2.den;
		dv_d.fin.res_real = sat_re.val;
		dv_d.fin.res_imag = sat_im.val;
		dv_d.fin.status   = (sat_re.sat || sat_im.sat) ? ST_SAT : ST_OK;
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			dv_s3[0] <= dv_d;
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		dv_t           nx;
		logic [CW-1:0] dsh;

		always_comb begin
			nx  = dv_s3[j];
			dsh = CW'(dv_s3[j].den) << K;
			if (CW'(dv_s3[j].rem_re) >= dsh) begin
				nx.rem_re    = dv_s3[j].rem_re - NW'(dsh);
				nx.q_re[K]   = 1'b1;
			end
			if (CW'(dv_s3[j].rem_im) >= dsh) begin
				nx.rem_im    = dv_s3[j].rem_im - NW'(dsh);
				nx.q_im[K]   = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[j+3]) begin
				dv_s3[j+1] <= nx;
			end
		end
	end

	// last stage: pick divide result or pass finished word
	sv_t qs_re, qs_im;

	always_comb begin
		qs_re = sat_fn(dv_s3[QW].neg_re,
			dv_s3[QW].ovf_re ? LIM + XW'(1) : XW'(dv_s3[QW].q_re));
		qs_im = sat_fn(dv_s3[QW].neg_im,
			dv_s3[QW].ovf_im ? LIM + XW'(1) : XW'(dv_s3[QW].q_im));
		res_d = dv_s3[QW].fin;
		if (dv_s3[QW].op == OP_DIV) begin
			if (dv_s3[QW].dz) begin
				res_d.res_real = '0;
				res_d.res_imag = '0;
				res_d.status   = ST_DIV0;
			end else begin
				res_d.res_real = qs_re.val;
				res_d.res_imag = qs_im.val;
				res_d.status   = (qs_re.sat || qs_im.sat) ? ST_SAT : ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NS-1]) begin
			res_sl <= res_d;
		end
	end

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_DIV0 |-> rsp.res_real == '0 && rsp.res_imag == '0)
		else $error("divide by zero word carries nonzero result");

	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[0] |-> !req_stall)
		else $error("input stalled with first stage empty");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW+2] && dv_s3[QW].op == OP_DIV && !dv_s3[QW].dz && !dv_s3[QW].ovf_re
		|-> CW'(dv_s3[QW].rem_re) < CW'(dv_s3[QW].den))
		else $error("divider remainder not below denominator");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for complex_arithmetic_unit_core: directed and random words,
// predicted results compared in order. Depends on cau_pkg and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	rsp_t expected_q[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycles = 0;
	bit idle_in = 1'b1;
	bit idle_out = 1'b1;

	complex_arithmetic_unit_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("complex_arithmetic_unit_core: mismatch");
			$finish;
		end
	end

	function automatic logic signed [DW-1:0] clamp16(input longint v, inout bit sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return DW'(v);
	endfunction

	function automatic longint mul_round(input longint x);
		longint m;
		m = (x < 0) ? -x : x;
		m = (m + 128) >>> FB;
		return (x < 0) ? -m : m;
	endfunction

	// truncate toward zero; large quotients saturate anyway
	function automatic longint div_trunc(input longint n, input longint den);
		longint m;
		m = (n < 0) ? -n : n;
		m = (m <<< FB) / den;
		return (n < 0) ? -m : m;
	endfunction

	function automatic rsp_t cplx_result(input req_t w);
		rsp_t r;
		bit sat;
		longint a, b, c, d, re, im, den;
		a = w.a_real;
		b = w.a_imag;
		c = w.b_real;
		d = w.b_imag;
		sat = 1'b0;
		re = 0;
		im = 0;
		case (w.opcode)
			OP_ADD: begin
				re = a + c;
				im = b + d;
			end
			OP_SUB: begin
				re = a - c;
				im = b - d;
			end
			OP_MUL: begin
				re = mul_round(a * c - b * d);
				im = mul_round(a * d + b * c);
			end
			default: begin
				den = c * c + d * d;
				if (den == 0) begin
					r.res_real = '0;
					r.res_imag = '0;
					r.status = ST_DIV0;
					return r;
				end
				re = div_trunc(a * c + b * d, den);
				im = div_trunc(b * c - a * d, den);
			end
		endcase
		r.res_real = clamp16(re, sat);
		r.res_imag = clamp16(im, sat);
		r.status = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("word %0d: %s got %0d expected %0d", words_checked, what, got, want);
	endtask

	task automatic send_word(input req_t w);
		if (idle_in && $urandom_range(0, 99) < 30) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_q.push_back(cplx_result(w));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic go_quiet();
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// output stall
	always @(negedge clk) begin
		rsp_stall <= idle_out && ($urandom_range(0, 99) < 30);
	end

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result word with nothing pending", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.res_real !== want.res_real)
					report_mismatch("res_real", rsp.res_real, want.res_real);
				if (rsp.res_imag !== want.res_imag)
					report_mismatch("res_imag", rsp.res_imag, want.res_imag);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				words_checked++;
			end
		end
	end

	function automatic req_t mk(input op_t op, input int ar, input int ai,
			input int br, input int bi);
		req_t w;
		w.opcode = op;
		w.a_real = DW'(ar);
		w.a_imag = DW'(ai);
		w.b_real = DW'(br);
		w.b_imag = DW'(bi);
		return w;
	endfunction

	function automatic logic [DW-1:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			2: return DW'($urandom_range(0, 1023) - 512);
			3: return DW'($urandom_range(0, 8191) - 4096);
			default: return DW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_word(mk(OP_ADD, 32767, -32768, 32767, -32768));
		send_word(mk(OP_ADD, 256, -256, 512, 128));
		send_word(mk(OP_SUB, -32768, 32767, 1, -1));
		send_word(mk(OP_SUB, 32767, 0, -32768, 0));
		send_word(mk(OP_SUB, 1000, -1000, 1000, -1000));
		send_word(mk(OP_MUL, 256, 256, 256, -256));
		send_word(mk(OP_MUL, 1, 0, 128, 0));     // tie rounds away from zero
		send_word(mk(OP_MUL, -1, 0, 128, 0));
		send_word(mk(OP_MUL, 1, 0, 127, 0));
		send_word(mk(OP_MUL, -32768, -32768, -32768, -32768));
		send_word(mk(OP_MUL, 32767, 32767, 32767, -32768));
		send_word(mk(OP_DIV, 256, 0, 0, 0));     // zero divisor
		send_word(mk(OP_DIV, 0, 0, 0, 0));
		send_word(mk(OP_DIV, 512, 256, 256, 0));
		send_word(mk(OP_DIV, 32767, 0, 1, 0));   // quotient overflow
		send_word(mk(OP_DIV, -32768, 0, 256, 0));
		send_word(mk(OP_DIV, 128, 0, 256, 0));
		send_word(mk(OP_DIV, -1, 1, 32767, -32768));
		send_word(mk(OP_DIV, 32767, -32768, 1, 1));
		send_word(mk(OP_DIV, 1, 0, 3, 0));
		send_word(mk(OP_DIV, -100, 37, -5, 0));
	endtask

	task automatic test_random(input int n);
		req_t w;
		repeat (n) begin
			w.opcode = op_t'($urandom_range(0, 3));
			w.a_real = rand_operand();
			w.a_imag = rand_operand();
			w.b_real = rand_operand();
			w.b_imag = rand_operand();
			send_word(w);
		end
	endtask

	task automatic test_back_to_back(input int n);
		idle_in = 1'b0;
		idle_out = 1'b0;
		test_random(n);
		idle_in = 1'b1;
		idle_out = 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		go_quiet();
		test_random(300);
		go_quiet();
		test_back_to_back(200);
		test_random(400);
		req_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (3 * NS) @(negedge clk);
		$display("sent %0d words over add, sub, mul, div with random idle and stall,", words_sent);
		$display("checked %0d result words", words_checked);
		if (errors == 0) begin
			$display("complex_arithmetic_unit_core: match");
		end else begin
			$display("complex_arithmetic_unit_core: mismatch");
		end
		$finish;
	end
endmodule

[complex_arithmetic_unit_core.f]
src/cau_pkg.sv
src/complex_arithmetic_unit_core.sv
tb/sv/testbench.sv
